// File: hw/rtl/pidl_pkg.sv
`timescale 1ns / 1ps
// pidl_pkg: shared sizes, codes and control structs for the positional list
// used by pidl_ctrl, pidl_cell and positional_insert_delete_list; no dependencies

package pidl_pkg;

  localparam int LIST_DEPTH    = 16;
  localparam int ELEMENT_WIDTH = 32;

  // fixed field widths of the request and result words
  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W    = $clog2(LIST_DEPTH);
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT     = 3'd4,
    OP_ERASE      = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // what every cell needs to pick its next word
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] at;
  } cell_ctl_t;

  // decoded request from pidl_ctrl
  typedef struct packed {
    status_t          status;
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] at;
    logic [CNT_W-1:0] cnt_nxt;
  } list_ctl_t;

endpackage

// File: hw/rtl/positional_insert_delete_list.sv
`timescale 1ns / 1ps
// positional_insert_delete_list: fixed-capacity ordered list built from a
// row of pidl_cell slots steered by pidl_ctrl; depends on pidl_pkg
//
//  channel | direction | handshake        | fields
//  in      | input     | in_valid/in_stall | operation, position, value
//  out     | output    | out_valid/out_stall | status, removed_value, count
//
// one word per cycle while in_stall is low: every slot shifts in parallel in the accept cycle
// result shows in the cycle after accept, in the output register
// rst_n clears the count and the output valid; slot contents stay unknown
// in_stall is high only while a result sits unread and out_stall is high

module positional_insert_delete_list import pidl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [POS_W-1:0]      in_position,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic signed [VAL_W-1:0] out_removed_value,
  output logic [CNT_W-1:0]      out_count
);

  logic                    acc;
  list_ctl_t               ctl;
  cell_ctl_t               cell_ctl;
  elem_t                   slot_q [LIST_DEPTH];
  elem_t                   new_elem;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r;
  logic signed [VAL_W-1:0] out_removed_value_r;
  logic [CNT_W-1:0]        out_count_r;

  assign in_stall = out_valid_r & out_stall;
  assign acc      = in_valid & ~in_stall;
  assign new_elem = elem_t'(in_value);

  pidl_ctrl u_ctrl (
    .operation (in_operation),
    .position  (in_position),
    .count     (count_r),
    .ctl       (ctl)
  );

  // slots only move on an accepted word
  assign cell_ctl.ins = acc & ctl.ins;
  assign cell_ctl.del = acc & ctl.del;
  assign cell_ctl.at  = ctl.at;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_slot
    elem_t lower;
    elem_t upper;
    if (i == 0) begin : g_first
      assign lower = new_elem;
    end else begin : g_lower
      assign lower = slot_q[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_last
      assign upper = slot_q[i];
    end else begin : g_upper
      assign upper = slot_q[i+1];
    end
    pidl_cell u_cell (
      .clk     (clk),
      .slot    (IDX_W'(i)),
      .ctl     (cell_ctl),
      .value   (new_elem),
      .lower_q (lower),
      .upper_q (upper),
      .q       (slot_q[i])
    );
  end

  assign count_nxt     = acc ? ctl.cnt_nxt : count_r;
  assign out_valid_nxt = acc | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_status_r        <= ctl.status;
      out_removed_value_r <= ctl.del ? VAL_W'(slot_q[ctl.at]) : '0;
      out_count_r         <= ctl.cnt_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_value_r;
  assign out_count         = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LIST_DEPTH))
    else $error("list count above capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cell_ctl.ins |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the count");

  a_err_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_removed_value_r == '0)
    else $error("refused request returned a value");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_count_r == count_r)
    else $error("result count differs from held count");

endmodule

// File: hw/rtl/pidl_ctrl.sv
`timescale 1ns / 1ps
// pidl_ctrl: decodes one request against the current count into status,
// shift direction, position and next count; depends on pidl_pkg

module pidl_ctrl import pidl_pkg::*; (
  input  logic [OP_W-1:0]  operation,
  input  logic [POS_W-1:0] position,
  input  logic [CNT_W-1:0] count,
  output list_ctl_t        ctl
);

  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] last;

  assign pos_x = CMP_W'(position);
  assign cnt_x = CMP_W'(count);
  assign full  = (count == CNT_W'(LIST_DEPTH));
  assign empty = (count == '0);
  assign last  = count - 1'b1;

  always_comb begin
    ctl.status = ST_OK;
    ctl.ins    = 1'b0;
    ctl.del    = 1'b0;
    ctl.at     = '0;
    unique case (operation)
      OP_PUSH_BACK: begin
        if (full) ctl.status = ST_FULL;
        else begin
          ctl.ins = 1'b1;
          ctl.at  = count[IDX_W-1:0];
        end
      end
      OP_PUSH_FRONT: begin
        if (full) ctl.status = ST_FULL;
        else ctl.ins = 1'b1;
      end
      OP_POP_BACK: begin
        if (empty) ctl.status = ST_EMPTY;
        else begin
          ctl.del = 1'b1;
          ctl.at  = last[IDX_W-1:0];
        end
      end
      OP_POP_FRONT: begin
        if (empty) ctl.status = ST_EMPTY;
        else ctl.del = 1'b1;
      end
      OP_INSERT: begin
        // range check wins over full
        if (pos_x > cnt_x) ctl.status = ST_RANGE;
        else if (full) ctl.status = ST_FULL;
        else begin
          ctl.ins = 1'b1;
          ctl.at  = position[IDX_W-1:0];
        end
      end
      OP_ERASE: begin
        if (empty) ctl.status = ST_EMPTY;
        else if (pos_x >= cnt_x) ctl.status = ST_RANGE;
        else begin
          ctl.del = 1'b1;
          ctl.at  = position[IDX_W-1:0];
        end
      end
      default: ;
    endcase

    priority if (operation == OP_CLEAR) ctl.cnt_nxt = '0;
    else if (ctl.ins)                   ctl.cnt_nxt = count + 1'b1;
    else if (ctl.del)                   ctl.cnt_nxt = count - 1'b1;
    else                                ctl.cnt_nxt = count;
  end

endmodule

// File: hw/rtl/pidl_cell.sv
`timescale 1ns / 1ps
// pidl_cell: one list slot; loads the new word, takes its lower neighbor on
// insert or its upper neighbor on erase; depends on pidl_pkg

module pidl_cell import pidl_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] slot,
  input  cell_ctl_t        ctl,
  input  elem_t            value,
  input  elem_t            lower_q,
  input  elem_t            upper_q,
  output elem_t            q
);

  elem_t data_r;

  always_ff @(posedge clk) begin
    priority if (ctl.ins && slot == ctl.at) data_r <= value;
    else if (ctl.ins && slot > ctl.at)      data_r <= lower_q;
    else if (ctl.del && slot >= ctl.at)     data_r <= upper_q;
    else                                    data_r <= data_r;
  end

  assign q = data_r;

endmodule

// File: bench/positional_insert_delete_list_test.sv
`timescale 1ns / 1ps
// positional_insert_delete_list_test: self-checking bench for the positional list,
// with a mirror of the list contents in a scoreboard class and random burst traffic
// depends on pidl_pkg and positional_insert_delete_list

typedef struct {
  pidl_pkg::status_t                      status;
  logic signed [pidl_pkg::VAL_W-1:0]      removed;
  logic [pidl_pkg::CNT_W-1:0]             count;
} list_result_t;

class list_mirror;
  pidl_pkg::elem_t cells[pidl_pkg::LIST_DEPTH];
  int unsigned     held;
  list_result_t    pending_results[$];
  int unsigned     errors;

  function new();
    held   = 0;
    errors = 0;
  endfunction

  // open a slot at the index, everything from there moves up one place
  function pidl_pkg::status_t place(int unsigned at, logic signed [pidl_pkg::VAL_W-1:0] val);
    if (held >= pidl_pkg::LIST_DEPTH) return pidl_pkg::ST_FULL;
    for (int unsigned i = held; i > at; i--) cells[i] = cells[i-1];
    cells[at] = pidl_pkg::elem_t'(val);
    held++;
    return pidl_pkg::ST_OK;
  endfunction

  function pidl_pkg::elem_t take(int unsigned at);
    pidl_pkg::elem_t v;
    v = cells[at];
    for (int unsigned i = at; i + 1 < held; i++) cells[i] = cells[i+1];
    held--;
    return v;
  endfunction

  function void note_request(logic [pidl_pkg::OP_W-1:0] op, logic [pidl_pkg::POS_W-1:0] pos,
                             logic signed [pidl_pkg::VAL_W-1:0] val);
    list_result_t r;
    r.status  = pidl_pkg::ST_OK;
    r.removed = '0;
    case (op)
      pidl_pkg::OP_PUSH_BACK:  r.status = place(held, val);
      pidl_pkg::OP_PUSH_FRONT: r.status = place(0, val);
      pidl_pkg::OP_POP_BACK: begin
        if (held == 0) r.status = pidl_pkg::ST_EMPTY;
        else r.removed = pidl_pkg::VAL_W'(take(held - 1));
      end
      pidl_pkg::OP_POP_FRONT: begin
        if (held == 0) r.status = pidl_pkg::ST_EMPTY;
        else r.removed = pidl_pkg::VAL_W'(take(0));
      end
      pidl_pkg::OP_INSERT: begin
        // range check wins over the full check
        if (pos > held) r.status = pidl_pkg::ST_RANGE;
        else r.status = place(pos, val);
      end
      pidl_pkg::OP_ERASE: begin
        // empty check wins over the range check
        if (held == 0) r.status = pidl_pkg::ST_EMPTY;
        else if (pos >= held) r.status = pidl_pkg::ST_RANGE;
        else r.removed = pidl_pkg::VAL_W'(take(pos));
      end
      pidl_pkg::OP_CLEAR: held = 0;
      default: ;
    endcase
    r.count = pidl_pkg::CNT_W'(held);
    pending_results.push_back(r);
  endfunction

  function void check_result(logic [pidl_pkg::STATUS_W-1:0] status,
                             logic signed [pidl_pkg::VAL_W-1:0] removed,
                             logic [pidl_pkg::CNT_W-1:0] count);
    list_result_t want;
    if (pending_results.size() == 0) begin
      $error("result word with no request outstanding");
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, status);
      errors++;
    end
    if (removed !== want.removed) begin
      $error("removed_value: expected %0d, got %0d", want.removed, removed);
      errors++;
    end
    if (count !== want.count) begin
      $error("count: expected %0d, got %0d", want.count, count);
      errors++;
    end
  endfunction
endclass

module positional_insert_delete_list_test;
  import pidl_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED  = 3'd7;
  localparam int RANDOM_WORDS = 1600;
  localparam int IDLE_LIMIT   = 5000;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} phase_kind_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [OP_W-1:0]         in_operation;
  logic [POS_W-1:0]        in_position;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic                    out_stall;
  logic [STATUS_W-1:0]     out_status;
  logic signed [VAL_W-1:0] out_removed_value;
  logic [CNT_W-1:0]        out_count;

  list_mirror sb;

  int unsigned stall_mode;
  int unsigned stall_tick;
  int unsigned idle_cycles;

  positional_insert_delete_list DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_position      (in_position),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_removed_value(out_removed_value),
    .out_count        (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // valid stays high if the caller sends the next word right away
  task automatic send_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                           logic signed [VAL_W-1:0] val);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_value     <= val;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, pos, val);
  endtask

  task automatic idle_input(int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [OP_W-1:0] pick_operation(phase_kind_t kind);
    int unsigned roll;
    int unsigned grow_pct;
    roll = $urandom_range(0, 99);
    case (kind)
      PH_GROW:   grow_pct = 78;
      PH_SHRINK: grow_pct = 22;
      default:   grow_pct = 50;
    endcase
    if (roll < 2) return OP_CLEAR;
    if (roll < 3) return OP_UNUSED;
    if (roll < 3 + grow_pct) begin
      case ($urandom_range(0, 2))
        0:       return OP_PUSH_BACK;
        1:       return OP_PUSH_FRONT;
        default: return OP_INSERT;
      endcase
    end
    case ($urandom_range(0, 2))
      0:       return OP_POP_BACK;
      1:       return OP_POP_FRONT;
      default: return OP_ERASE;
    endcase
  endfunction

  // mostly indexes up to the count, some up to the list depth, a few anywhere in the field
  function automatic logic [POS_W-1:0] pick_position(int unsigned held);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return POS_W'($urandom_range(0, held));
    if (roll < 9) return POS_W'($urandom_range(0, LIST_DEPTH));
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 9) != 0) return VAL_W'($urandom);
    case ($urandom_range(0, 3))
      0:       return {1'b0, {(VAL_W-1){1'b1}}};
      1:       return {1'b1, {(VAL_W-1){1'b0}}};
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // receiver stall pattern, which switches among four styles
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 50 == 49) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick % 5 < 3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_removed_value, out_count);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    phase_kind_t phase;
    int unsigned sent;
    int unsigned phase_len;
    int unsigned burst_left;
    bit          no_gaps;

    sb = new();
    stall_mode  = 0;
    stall_tick  = 0;
    idle_cycles = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= '0;
    in_position  <= '0;
    in_value     <= '0;
    out_stall    <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list refusals first
    send_word(OP_POP_BACK, 5'd0, 32'sd0);
    send_word(OP_POP_FRONT, 5'd0, 32'sd0);
    send_word(OP_ERASE, 5'd0, 32'sd0);
    send_word(OP_ERASE, 5'd31, 32'sd0);
    idle_input(2);
    send_word(OP_INSERT, 5'd1, 32'sd7);
    send_word(OP_INSERT, 5'd0, 32'h7fffffff);
    send_word(OP_PUSH_BACK, 5'd31, 32'h80000000);
    send_word(OP_PUSH_FRONT, 5'd16, -32'sd1);
    send_word(OP_PUSH_FRONT, 5'd0, 32'sd0);
    idle_input(3);
    send_word(OP_INSERT, 5'd2, 32'h55555555);
    send_word(OP_INSERT, 5'd5, 32'haaaaaaaa);
    send_word(OP_INSERT, 5'd31, 32'sd1);
    send_word(OP_ERASE, 5'd6, 32'sd0);
    send_word(OP_ERASE, 5'd5, 32'sd0);
    send_word(OP_ERASE, 5'd1, 32'sd0);
    send_word(OP_UNUSED, 5'd31, 32'hffffffff);
    idle_input(1);
    send_word(OP_POP_FRONT, 5'd0, 32'sd0);
    send_word(OP_POP_BACK, 5'd0, 32'sd0);
    send_word(OP_CLEAR, 5'd0, 32'sd0);
    send_word(OP_CLEAR, 5'd0, 32'sd0);
    send_word(OP_PUSH_BACK, 5'd0, 32'sd42);
    idle_input(4);

    sent       = 0;
    burst_left = $urandom_range(1, 12);
    while (sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 2))
        0:       phase = PH_GROW;
        1:       phase = PH_SHRINK;
        default: phase = PH_MIXED;
      endcase
      phase_len = $urandom_range(20, 60);
      no_gaps   = ($urandom_range(0, 3) == 0);
      for (int unsigned k = 0; k < phase_len; k++) begin
        send_word(pick_operation(phase), pick_position(sb.held), pick_value());
        sent++;
        if (burst_left == 0) begin
          if (!no_gaps) idle_input($urandom_range(1, 6));
          burst_left = $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
